@@ rtl/pew_pkg.sv @@
// Package for the particle Euler step block: field widths, fixed-point constants,
// command codes and saturating arithmetic helpers.
// No dependencies; imported by pew_divider and the core.
package pew_pkg;

   localparam int unsigned Q_W        = 32;          // signed Q16.16 word
   localparam int unsigned FRAC_W     = 16;
   localparam int unsigned MASS_W     = 31;          // unsigned Q15.16 mass
   localparam int unsigned DT_W       = 31;          // unsigned Q15.16 step
   localparam int unsigned DIV_NUM_W  = Q_W + FRAC_W; // |force| << 16
   localparam int unsigned PROD_W     = Q_W + DT_W;
   localparam int unsigned AXES       = 3;
   localparam int unsigned AXIS_W     = 2;
   localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

   localparam logic [MASS_W-1:0] MASS_RESET = MASS_W'(65536);
   localparam logic [DT_W-1:0]   DAMP_Q16   = DT_W'(64225);   // 0.98
   localparam logic signed [Q_W-1:0] WALL_LIMIT = Q_W'(393216); // 6.0
   localparam logic signed [Q_W-1:0] WALL_CLAMP = Q_W'(386662); // 5.9
   localparam logic [6:0]  REST_SQ_LIMIT = 7'd43;
   localparam logic [Q_W-1:0] REST_MAG_MAX = Q_W'(6);

   localparam logic signed [Q_W-1:0] S_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic signed [Q_W-1:0] S_MIN = {1'b1, {(Q_W-1){1'b0}}};

   typedef enum logic [1:0] {
      CMD_INTEGRATE = 2'd0,
      CMD_WALL      = 2'd1,
      CMD_LOAD      = 2'd2
   } cmd_type;

   // magnitude of a signed word; the most negative value maps to 2^31
   function automatic logic [Q_W-1:0] mag_of(input logic signed [Q_W-1:0] v);
      return v[Q_W-1] ? Q_W'(-v) : Q_W'(v);
   endfunction

   // sign + magnitude back to a saturated signed word
   function automatic logic signed [Q_W-1:0] sat_from_mag(
      input logic                 neg,
      input logic [DIV_NUM_W-1:0] mag
   );
      logic big;
      big = |mag[DIV_NUM_W-1:Q_W-1];
      if (neg) begin
         return big ? S_MIN : -$signed(mag[Q_W-1:0]);
      end
      return big ? S_MAX : $signed(mag[Q_W-1:0]);
   endfunction

   function automatic logic signed [Q_W-1:0] sat_add(
      input logic signed [Q_W-1:0] a,
      input logic signed [Q_W-1:0] b
   );
      logic signed [Q_W:0] s;
      s = {a[Q_W-1], a} + {b[Q_W-1], b};
      if (s[Q_W] != s[Q_W-1]) begin
         return s[Q_W] ? S_MIN : S_MAX;
      end
      return s[Q_W-1:0];
   endfunction

   function automatic logic signed [Q_W-1:0] sat_neg(input logic signed [Q_W-1:0] v);
      return (v == S_MIN) ? S_MAX : -v;
   endfunction

endpackage

@@ rtl/particle_euler_step_with_walls_core.sv @@
// Particle integrator core: sequencer, shared multiplier and state registers.
// Depends on pew_pkg and pew_divider.
//
//   channel | direction | handshake        | payload
//   req     | in        | valid / stall    | command, force xyz, delta_time, load pos/vel
//   rsp     | out       | valid / stall    | pos xyz, vel xyz, hit_x_wall, hit_z_wall
//   csr     | in        | valid / ready    | mass (31 bit unsigned Q15.16)
//
// Integrate works the axes in turn. Each axis takes a divider start, the 48-step
// bit-serial divide and its done pulse, and three passes through the one 32x31
// multiplier with their adds. Then come a rest-check state and the write into
// the output register. Wall check passes through ST_WALL; load and the unused
// code go straight to ST_FINISH.
// reset is synchronous: state and position/velocity clear, mass returns to 1.0.
// req_stall is high while an item is in work; the next item can be taken while
// a result waits on rsp_stall, and one further result waits inside.
module particle_euler_step_with_walls_core
   import pew_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,

   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_command,
   input  logic signed [Q_W-1:0]   req_force_x,
   input  logic signed [Q_W-1:0]   req_force_y,
   input  logic signed [Q_W-1:0]   req_force_z,
   input  logic [DT_W-1:0]         req_delta_time,
   input  logic signed [Q_W-1:0]   req_load_pos_x,
   input  logic signed [Q_W-1:0]   req_load_pos_y,
   input  logic signed [Q_W-1:0]   req_load_pos_z,
   input  logic signed [Q_W-1:0]   req_load_vel_x,
   input  logic signed [Q_W-1:0]   req_load_vel_y,
   input  logic signed [Q_W-1:0]   req_load_vel_z,

   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [Q_W-1:0]   rsp_pos_x,
   output logic signed [Q_W-1:0]   rsp_pos_y,
   output logic signed [Q_W-1:0]   rsp_pos_z,
   output logic signed [Q_W-1:0]   rsp_vel_x,
   output logic signed [Q_W-1:0]   rsp_vel_y,
   output logic signed [Q_W-1:0]   rsp_vel_z,
   output logic                    rsp_hit_x_wall,
   output logic                    rsp_hit_z_wall,

   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [MASS_W-1:0]       csr_mass
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_MUL_ACC,
      ST_ADD_VEL,
      ST_MUL_POS,
      ST_ADD_POS,
      ST_MUL_DAMP,
      ST_DAMP_WB,
      ST_REST,
      ST_WALL,
      ST_FINISH
   } state_type;

   state_type state_ff;

   // axis registers rotate after each integrate axis, so the working axis is
   // always entry 0; three rotations restore x, y, z order
   logic signed [Q_W-1:0] pos_ff   [AXES];
   logic signed [Q_W-1:0] vel_ff   [AXES];
   logic signed [Q_W-1:0] force_ff [AXES];
   logic [DT_W-1:0]       dt_ff;
   logic [MASS_W-1:0]     mass_ff;
   logic [AXIS_W-1:0]     axis_ff;
   logic signed [Q_W-1:0] acc_ff;
   logic                  hit_x_ff, hit_z_ff;

   logic                  rsp_valid_ff;
   logic signed [Q_W-1:0] rsp_pos_ff [AXES];
   logic signed [Q_W-1:0] rsp_vel_ff [AXES];
   logic                  rsp_hit_x_ff, rsp_hit_z_ff;

   // shared multiplier, registered
   logic signed [Q_W-1:0] mul_a;
   logic [DT_W-1:0]       mul_b;
   logic [PROD_W-1:0]     prod_ff;
   logic                  prod_neg_ff;
   logic signed [Q_W-1:0] prod_q;

   // divider
   logic                  div_start, div_done;
   logic [DIV_NUM_W-1:0]  div_dividend, div_quotient;
   logic [MASS_W-1:0]     div_divisor;

   logic                  accept;
   logic [Q_W-1:0]        vmag [AXES];
   logic                  rest_small;
   logic [6:0]            rest_sq;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // operand select for the one multiplier
   always_comb begin
      unique case (state_ff)
         ST_MUL_ACC: begin
            mul_a = acc_ff;
            mul_b = dt_ff;
         end
         ST_MUL_POS: begin
            mul_a = vel_ff[0];
            mul_b = dt_ff;
         end
         ST_MUL_DAMP: begin
            mul_a = vel_ff[0];
            mul_b = DAMP_Q16;
         end
         default: begin
            mul_a = acc_ff;
            mul_b = dt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff     <= PROD_W'(mag_of(mul_a)) * PROD_W'(mul_b);
      prod_neg_ff <= mul_a[Q_W-1];
   end

   // Q16.16 product: drop fraction bits, toward zero, saturate
   assign prod_q = sat_from_mag(prod_neg_ff, DIV_NUM_W'(prod_ff[PROD_W-1:FRAC_W]));

   assign div_start    = (state_ff == ST_DIV_START);
   assign div_dividend = {mag_of(force_ff[0]), {FRAC_W{1'b0}}};
   assign div_divisor  = (mass_ff == '0) ? MASS_W'(1) : mass_ff;

   pew_divider #(
      .NUM_W (DIV_NUM_W),
      .DEN_W (MASS_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // rest check: only velocities with every |v| <= 6 can fall below the limit
   always_comb begin
      rest_small = 1'b1;
      rest_sq    = '0;
      for (int i = 0; i < AXES; i++) begin
         vmag[i] = mag_of(vel_ff[i]);
         if (vmag[i] > REST_MAG_MAX) begin
            rest_small = 1'b0;
         end
         rest_sq = rest_sq + 7'(vmag[i][2:0]) * 7'(vmag[i][2:0]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         mass_ff      <= MASS_RESET;
         axis_ff      <= '0;
         hit_x_ff     <= 1'b0;
         hit_z_ff     <= 1'b0;
         for (int i = 0; i < AXES; i++) begin
            pos_ff[i] <= '0;
            vel_ff[i] <= '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            mass_ff <= csr_mass;
         end
         // a free output register is refilled in ST_FINISH instead
         if (!rsp_stall && state_ff != ST_FINISH) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  force_ff[0] <= req_force_x;
                  force_ff[1] <= req_force_y;
                  force_ff[2] <= req_force_z;
                  dt_ff       <= req_delta_time;
                  hit_x_ff    <= 1'b0;
                  hit_z_ff    <= 1'b0;
                  axis_ff     <= '0;
                  unique case (req_command)
                     CMD_INTEGRATE: state_ff <= ST_DIV_START;
                     CMD_WALL:      state_ff <= ST_WALL;
                     CMD_LOAD: begin
                        pos_ff[0] <= req_load_pos_x;
                        pos_ff[1] <= req_load_pos_y;
                        pos_ff[2] <= req_load_pos_z;
                        vel_ff[0] <= req_load_vel_x;
                        vel_ff[1] <= req_load_vel_y;
                        vel_ff[2] <= req_load_vel_z;
                        state_ff  <= ST_FINISH;
                     end
                     default:       state_ff <= ST_FINISH;  // unused code: report only
                  endcase
               end
            end
            ST_DIV_START: state_ff <= ST_DIV_WAIT;
            ST_DIV_WAIT: begin
               if (div_done) begin
                  acc_ff   <= sat_from_mag(force_ff[0][Q_W-1], div_quotient);
                  state_ff <= ST_MUL_ACC;
               end
            end
            ST_MUL_ACC: state_ff <= ST_ADD_VEL;
            ST_ADD_VEL: begin
               vel_ff[0] <= sat_add(vel_ff[0], prod_q);
               state_ff  <= ST_MUL_POS;
            end
            ST_MUL_POS: state_ff <= ST_ADD_POS;
            ST_ADD_POS: begin
               pos_ff[0] <= sat_add(pos_ff[0], prod_q);
               state_ff  <= ST_MUL_DAMP;
            end
            ST_MUL_DAMP: state_ff <= ST_DAMP_WB;
            ST_DAMP_WB: begin
               // write damped velocity and rotate to the next axis
               pos_ff[0]   <= pos_ff[1];
               pos_ff[1]   <= pos_ff[2];
               pos_ff[2]   <= pos_ff[0];
               vel_ff[0]   <= vel_ff[1];
               vel_ff[1]   <= vel_ff[2];
               vel_ff[2]   <= prod_q;
               force_ff[0] <= force_ff[1];
               force_ff[1] <= force_ff[2];
               force_ff[2] <= force_ff[0];
               if (axis_ff == LAST_AXIS) begin
                  state_ff <= ST_REST;
               end else begin
                  axis_ff  <= axis_ff + AXIS_W'(1);
                  state_ff <= ST_DIV_START;
               end
            end
            ST_REST: begin
               if (rest_small && (rest_sq < REST_SQ_LIMIT)) begin
                  for (int i = 0; i < AXES; i++) begin
                     vel_ff[i] <= '0;
                  end
               end
               state_ff <= ST_FINISH;
            end
            ST_WALL: begin
               // x and z are independent; y has no walls
               if (pos_ff[2] > WALL_LIMIT || pos_ff[2] < -WALL_LIMIT) begin
                  pos_ff[2] <= (pos_ff[2] > WALL_LIMIT) ? WALL_CLAMP : -WALL_CLAMP;
                  vel_ff[2] <= sat_neg(vel_ff[2]);
                  hit_z_ff  <= 1'b1;
               end
               if (pos_ff[0] > WALL_LIMIT || pos_ff[0] < -WALL_LIMIT) begin
                  pos_ff[0] <= (pos_ff[0] > WALL_LIMIT) ? WALL_CLAMP : -WALL_CLAMP;
                  vel_ff[0] <= sat_neg(vel_ff[0]);
                  hit_x_ff  <= 1'b1;
               end
               state_ff <= ST_FINISH;
            end
            ST_FINISH: begin
               // hold until the output register is free
               if (!rsp_valid_ff || !rsp_stall) begin
                  for (int i = 0; i < AXES; i++) begin
                     rsp_pos_ff[i] <= pos_ff[i];
                     rsp_vel_ff[i] <= vel_ff[i];
                  end
                  rsp_hit_x_ff <= hit_x_ff;
                  rsp_hit_z_ff <= hit_z_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pos_x      = rsp_pos_ff[0];
   assign rsp_pos_y      = rsp_pos_ff[1];
   assign rsp_pos_z      = rsp_pos_ff[2];
   assign rsp_vel_x      = rsp_vel_ff[0];
   assign rsp_vel_y      = rsp_vel_ff[1];
   assign rsp_vel_z      = rsp_vel_ff[2];
   assign rsp_hit_x_wall = rsp_hit_x_ff;
   assign rsp_hit_z_wall = rsp_hit_z_ff;

endmodule

@@ rtl/pew_divider.sv @@
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on pew_pkg for default widths.
module pew_divider
   import pew_pkg::*;
#(
   parameter int unsigned NUM_W = DIV_NUM_W,
   parameter int unsigned DEN_W = MASS_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,   // must be nonzero
   output logic             done,      // one-cycle pulse, quotient valid
   output logic [NUM_W-1:0] quotient
);

   localparam int unsigned CNT_W = $clog2(NUM_W + 1);

   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0] quo_ff;
   logic [CNT_W-1:0] count_ff;
   logic             busy_ff, done_ff;
   logic [DEN_W:0]   shifted, diff;
   logic             ge;

   always_comb begin
      shifted = {rem_ff, quo_ff[NUM_W-1]};
      diff    = shifted - {1'b0, divisor};
      ge      = shifted >= {1'b0, divisor};
      rem_in  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff   <= '0;
            quo_ff   <= dividend;
            count_ff <= CNT_W'(NUM_W);
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            rem_ff   <= rem_in;
            quo_ff   <= {quo_ff[NUM_W-2:0], ge};
            count_ff <= count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
